// ----- src/gef_pkg.sv -----
// Shared types, codes and the control program of the gated envelope follower.
`default_nettype none

package gef_pkg;

    // Width of the output voltage field.
    localparam int OUT_BITS = 15;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLEW    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMOUNT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTOUR = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEGACY  = 3'd5;

    // Datapath operations.
    typedef logic [3:0] t_op;
    localparam t_op OP_IDLE       = 4'd0;
    localparam t_op OP_S1         = 4'd1;
    localparam t_op OP_S2         = 4'd2;
    localparam t_op OP_S3         = 4'd3;
    localparam t_op OP_S4         = 4'd4;
    localparam t_op OP_ENV        = 4'd5;
    localparam t_op OP_NOP        = 4'd6;
    localparam t_op OP_SQ_MUL     = 4'd7;
    localparam t_op OP_SQ_APPLY   = 4'd8;
    localparam t_op OP_SQRT_GO    = 4'd9;
    localparam t_op OP_SQRT_TAKE  = 4'd10;
    localparam t_op OP_PROD_MUL   = 4'd11;
    localparam t_op OP_PROD_APPLY = 4'd12;
    localparam t_op OP_OUT        = 4'd13;

    // Sequencer branch conditions.
    typedef logic [2:0] t_cond;
    localparam t_cond JC_NEXT      = 3'd0;
    localparam t_cond JC_GOTO      = 3'd1;
    localparam t_cond JC_WAIT_IN   = 3'd2;
    localparam t_cond JC_IF_LINEAR = 3'd3;
    localparam t_cond JC_IF_SQRT   = 3'd4;
    localparam t_cond JC_WAIT_SQRT = 3'd5;
    localparam t_cond JC_WAIT_OUT  = 3'd6;

    // Step addresses of the program.
    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] t_pc;
    localparam t_pc PC_IDLE       = 4'd0;
    localparam t_pc PC_S1         = 4'd1;
    localparam t_pc PC_S2         = 4'd2;
    localparam t_pc PC_S3         = 4'd3;
    localparam t_pc PC_S4         = 4'd4;
    localparam t_pc PC_ENV        = 4'd5;
    localparam t_pc PC_SHAPE_SEL  = 4'd6;
    localparam t_pc PC_SQ_MUL     = 4'd7;
    localparam t_pc PC_SQ_APPLY   = 4'd8;
    localparam t_pc PC_SQRT_GO    = 4'd9;
    localparam t_pc PC_SQRT_WAIT  = 4'd10;
    localparam t_pc PC_PROD_MUL   = 4'd11;
    localparam t_pc PC_PROD_APPLY = 4'd12;
    localparam t_pc PC_OUT        = 4'd13;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_accept;
        logic shape_linear;
        logic shape_sqrt;
        logic sqrt_busy;
        logic out_full;
    } t_dp_status;

    // Control store: one word per step.
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:       w = '{OP_IDLE,       JC_WAIT_IN,   PC_IDLE};
            PC_S1:         w = '{OP_S1,         JC_NEXT,      PC_IDLE};
            PC_S2:         w = '{OP_S2,         JC_NEXT,      PC_IDLE};
            PC_S3:         w = '{OP_S3,         JC_NEXT,      PC_IDLE};
            PC_S4:         w = '{OP_S4,         JC_NEXT,      PC_IDLE};
            PC_ENV:        w = '{OP_ENV,        JC_IF_LINEAR, PC_PROD_MUL};
            PC_SHAPE_SEL:  w = '{OP_NOP,        JC_IF_SQRT,   PC_SQRT_GO};
            PC_SQ_MUL:     w = '{OP_SQ_MUL,     JC_NEXT,      PC_IDLE};
            PC_SQ_APPLY:   w = '{OP_SQ_APPLY,   JC_GOTO,      PC_PROD_MUL};
            PC_SQRT_GO:    w = '{OP_SQRT_GO,    JC_NEXT,      PC_IDLE};
            PC_SQRT_WAIT:  w = '{OP_SQRT_TAKE,  JC_WAIT_SQRT, PC_IDLE};
            PC_PROD_MUL:   w = '{OP_PROD_MUL,   JC_NEXT,      PC_IDLE};
            PC_PROD_APPLY: w = '{OP_PROD_APPLY, JC_NEXT,      PC_IDLE};
            PC_OUT:        w = '{OP_OUT,        JC_WAIT_OUT,  PC_IDLE};
            default:       w = '{OP_NOP,        JC_GOTO,      PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/gef_in_if.sv -----
// Request channel carrying one gate sample and one audio sample.
`default_nettype none

interface gef_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] gate_voltage;
    logic signed [SAMPLE_BITS-1:0] audio_voltage;
    logic                          gate_present;
    logic                          audio_present;

    modport source (
        output valid, gate_voltage, audio_voltage, gate_present, audio_present,
        input  ready
    );
    modport sink (
        input  valid, gate_voltage, audio_voltage, gate_present, audio_present,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/gef_out_if.sv -----
// Result channel carrying one control voltage per request.
`default_nettype none

interface gef_out_if
    import gef_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] out_voltage;

    modport source (output valid, out_voltage, input ready);
    modport sink (input valid, out_voltage, output ready);
endinterface

`default_nettype wire

// ----- src/gef_sqrt.sv -----
// Bit-serial integer square root of a Q0.F value, one result bit per cycle.
`default_nettype none

module gef_sqrt
    import gef_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [FRAC_BITS-1:0] i_radicand,
    output logic                      o_busy,
    output logic [FRAC_BITS-1:0]      o_root
);
    localparam int F  = FRAC_BITS;
    localparam int CW = $clog2(F + 1);

    logic [2*F-1:0] r_rad;
    logic [F+1:0]   r_rem;
    logic [F-1:0]   r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;

    logic [F+1:0] rem_sh;
    logic [F+1:0] trial;
    logic         fits;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {r_rem[F-1:0], r_rad[2*F-1:2*F-2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(F);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // The radicand is x scaled by 2^F, so its low half is zero.
            r_rad  <= {i_radicand, {F{1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*F-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[F-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ----- src/gef_datapath.sv -----
// Datapath: followers, amount smoother, shared multiplier, shaping and output register.
`default_nettype none

module gef_datapath
    import gef_pkg::*;
#(
    parameter int FRAC_BITS   = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_uword                        i_uword,
    output t_dp_status                         o_status,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_gate_voltage,
    input  wire logic signed [SAMPLE_BITS-1:0] i_audio_voltage,
    input  wire logic                          i_gate_present,
    input  wire logic                          i_audio_present,
    input  wire logic [FRAC_BITS:0]            i_attack_coeff,
    input  wire logic [FRAC_BITS:0]            i_release_coeff,
    input  wire logic [FRAC_BITS:0]            i_amount_slew_coeff,
    input  wire logic [FRAC_BITS:0]            i_amount_target,
    input  wire logic [1:0]                    i_contour_mode,
    input  wire logic                          i_legacy_contour_map,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [OUT_BITS-1:0]                o_out_voltage
);
    localparam int F = FRAC_BITS;
    localparam int W = FRAC_BITS + 1;
    localparam int S = SAMPLE_BITS;

    localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0] ONE_M1 = {1'b0, {F{1'b1}}};

    // Audio target: floor(|v| * 2^F / 10240) = q * 2^(F-11) + floor(r * 2^(F-11) / 5)
    // with |v| = 5q + r.
    localparam logic [63:0] FRAC_R1 = (64'd1 << (FRAC_BITS - 11)) / 5;
    localparam logic [63:0] FRAC_R2 = (64'd2 << (FRAC_BITS - 11)) / 5;
    localparam logic [63:0] FRAC_R3 = (64'd3 << (FRAC_BITS - 11)) / 5;
    localparam logic [63:0] FRAC_R4 = (64'd4 << (FRAC_BITS - 11)) / 5;
    localparam logic [13:0] RECIP5  = 14'd13108;
    localparam logic [31:0] FIVE_VOLT = 32'd10240;
    localparam logic signed [31:0] GATE_HIGH = 32'sd2048;
    localparam logic signed [31:0] GATE_LOW  = 32'sd205;
    localparam logic [OUT_BITS-1:0] OUT_MAX = 15'd20480;

    function automatic logic [W-1:0] sat_one(input logic [W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    // Item and state registers.
    logic signed [S-1:0] r_gv;
    logic signed [S-1:0] r_av;
    logic                r_gp;
    logic                r_ap;
    logic [W-1:0]        r_amt;
    logic [W-1:0]        r_gate_lvl;
    logic [W-1:0]        r_audio_lvl;
    logic                r_gate_hi;
    logic                r_gate_tgt;
    logic [10:0]         r_qm;
    logic [13:0]         r_mag14;
    logic                r_abig;
    logic [W-1:0]        r_atgt;
    logic [W-1:0]        r_shaped;

    // Shared multiplier registers.
    logic [2*F:0] r_prod;
    logic         r_m_one;
    logic [W-1:0] r_m_b;
    logic         r_m_ceil;
    logic         r_m_up;

    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_voltage;

    logic accept;
    logic out_full;

    // Multiplier operand selection.
    logic [W-1:0] m_a;
    logic [W-1:0] m_b;
    logic         m_ceil;
    logic         m_up;
    logic [W-1:0] amt_t;
    logic [W-1:0] gate_t;
    logic [2*F+1:0] m_sum;
    logic [W-1:0] m_res;

    // Rectifier and audio target.
    logic signed [31:0] a32;
    logic signed [31:0] g32;
    logic [31:0]        mag;
    logic [27:0]        qm_prod;
    logic [13:0]        five_q;
    logic [13:0]        rem_full;
    logic [W-1:0]       frac_r;
    logic [W-1:0]       atgt_calc;
    logic               gate_next;

    // Output scaling: round(p * 20480 / 2^F), with 20480 = 5 * 2^12.
    logic [F+3:0]       p5;
    logic [F+15:0]      out_sum;

    // Square root unit.
    logic               sqrt_busy;
    logic [F-1:0]       sqrt_root;

    logic shape_square;
    logic shape_sqrt;

    assign o_in_ready = (i_uword.op == OP_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_full   = r_out_valid && !i_out_ready;

    assign shape_square = (i_contour_mode == 2'd1);
    assign shape_sqrt   = i_legacy_contour_map ? (i_contour_mode == 2'd0)
                                               : (i_contour_mode == 2'd2);

    assign o_status.in_accept    = accept;
    assign o_status.shape_linear = !shape_square && !shape_sqrt;
    assign o_status.shape_sqrt   = shape_sqrt;
    assign o_status.sqrt_busy    = sqrt_busy;
    assign o_status.out_full     = out_full;

    assign amt_t  = sat_one(i_amount_target);
    assign gate_t = r_gate_tgt ? ONE : '0;

    always_comb begin
        m_a    = '0;
        m_b    = '0;
        m_ceil = 1'b0;
        m_up   = 1'b0;
        unique case (i_uword.op)
            OP_S1: begin
                m_up   = (amt_t > r_amt);
                m_a    = sat_one(i_amount_slew_coeff);
                m_b    = m_up ? (amt_t - r_amt) : (r_amt - amt_t);
                m_ceil = 1'b1;
            end
            OP_S2: begin
                m_up   = (gate_t > r_gate_lvl);
                m_a    = m_up ? sat_one(i_attack_coeff) : sat_one(i_release_coeff);
                m_b    = m_up ? (gate_t - r_gate_lvl) : (r_gate_lvl - gate_t);
                m_ceil = 1'b1;
            end
            OP_S3: begin
                m_up   = (r_atgt > r_audio_lvl);
                m_a    = m_up ? sat_one(i_attack_coeff) : sat_one(i_release_coeff);
                m_b    = m_up ? (r_atgt - r_audio_lvl) : (r_audio_lvl - r_atgt);
                m_ceil = 1'b1;
            end
            OP_SQ_MUL: begin
                m_a = r_shaped;
                m_b = r_shaped;
            end
            OP_PROD_MUL: begin
                m_a = r_shaped;
                m_b = r_amt;
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    // A factor of exactly one passes the other operand through unchanged.
    assign m_sum = {1'b0, r_prod} + (r_m_ceil ? (2*F+2)'(ONE_M1) : '0);
    assign m_res = r_m_one ? r_m_b : m_sum[2*F:F];

    assign g32      = 32'(r_gv);
    assign a32      = 32'(r_av);
    assign mag      = a32[31] ? unsigned'(-a32) : unsigned'(a32);
    assign qm_prod  = 28'(mag[13:0]) * 28'(RECIP5);
    assign five_q   = {1'b0, r_qm, 2'b00} + 14'(r_qm);
    assign rem_full = r_mag14 - five_q;

    always_comb begin
        case (rem_full[2:0])
            3'd1:    frac_r = FRAC_R1[W-1:0];
            3'd2:    frac_r = FRAC_R2[W-1:0];
            3'd3:    frac_r = FRAC_R3[W-1:0];
            3'd4:    frac_r = FRAC_R4[W-1:0];
            default: frac_r = '0;
        endcase
    end

    assign atgt_calc = !r_ap  ? '0 :
                       r_abig ? ONE :
                       ((W'(r_qm) << (F - 11)) + frac_r);

    // Schmitt trigger: rises above 1 V, falls below 0.1 V.
    assign gate_next = r_gate_hi ? !(g32 < GATE_LOW) : (g32 > GATE_HIGH);

    assign p5      = ((F+4)'(r_shaped) << 2) + (F+4)'(r_shaped);
    assign out_sum = {p5, 12'b0} + ((F+16)'(1) << (F - 1));

    gef_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_uword.op == OP_SQRT_GO),
        .i_radicand (r_shaped[F-1:0]),
        .o_busy     (sqrt_busy),
        .o_root     (sqrt_root)
    );

    // Operand capture and multiplier stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gv <= i_gate_voltage;
            r_av <= i_audio_voltage;
            r_gp <= i_gate_present;
            r_ap <= i_audio_present;
        end
        r_prod   <= (2*F+1)'(m_a[F-1:0]) * (2*F+1)'(m_b);
        r_m_one  <= m_a[F];
        r_m_b    <= m_b;
        r_m_ceil <= m_ceil;
        r_m_up   <= m_up;
    end

    // Work registers that carry no state between requests.
    always_ff @(posedge i_clk) begin
        unique case (i_uword.op)
            OP_S1: begin
                r_gate_tgt <= r_gp && gate_next;
                r_qm       <= qm_prod[26:16];
                r_mag14    <= mag[13:0];
                r_abig     <= (mag >= FIVE_VOLT);
            end
            OP_S2: begin
                r_atgt <= atgt_calc;
            end
            OP_ENV: begin
                r_shaped <= (r_gate_lvl > r_audio_lvl) ? r_gate_lvl : r_audio_lvl;
            end
            OP_SQ_APPLY, OP_PROD_APPLY: begin
                r_shaped <= m_res;
            end
            OP_SQRT_TAKE: begin
                if (!sqrt_busy && !r_shaped[F]) begin
                    r_shaped <= {1'b0, sqrt_root};
                end
            end
            default: begin
                r_shaped <= r_shaped;
            end
        endcase
    end

    // Follower and smoother state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amt       <= ONE;
            r_gate_lvl  <= '0;
            r_audio_lvl <= '0;
            r_gate_hi   <= 1'b0;
        end else begin
            unique case (i_uword.op)
                OP_S1: begin
                    r_gate_hi <= r_gp && gate_next;
                end
                OP_S2: begin
                    r_amt <= r_m_up ? (r_amt + m_res) : (r_amt - m_res);
                end
                OP_S3: begin
                    r_gate_lvl <= r_m_up ? (r_gate_lvl + m_res) : (r_gate_lvl - m_res);
                end
                OP_S4: begin
                    r_audio_lvl <= r_m_up ? (r_audio_lvl + m_res) : (r_audio_lvl - m_res);
                end
                default: begin
                    r_amt <= r_amt;
                end
            endcase
        end
    end

    // Output register; the sequencer loads it only while it is free.
    // A waiting result stays until taken; a new one can load as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_full || (i_uword.op == OP_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_uword.op == OP_OUT) && !out_full) begin
            r_out_voltage <= out_sum[F+14:F];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_voltage = r_out_voltage;

    a_levels_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gate_lvl <= ONE) && (r_audio_lvl <= ONE) && (r_amt <= ONE))
        else $error("follower or amount level above one");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_uword.op == OP_OUT) && !out_full) |=> r_out_valid)
        else $error("result not presented after output step");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_voltage <= OUT_MAX))
        else $error("output voltage above ten volts");

endmodule

`default_nettype wire

// ----- src/gef_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and branch logic.
`default_nettype none

module gef_sequencer
    import gef_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_status i_status,
    output t_uword          o_uword
);
    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    t_uword             uw;
    logic [PC_BITS-1:0] pc_inc;

    assign uw     = ucode_rom(r_pc);
    assign pc_inc = r_pc + PC_BITS'(1);

    always_comb begin
        unique case (uw.cond)
            JC_NEXT:      n_pc = pc_inc;
            JC_GOTO:      n_pc = uw.target;
            JC_WAIT_IN:   n_pc = i_status.in_accept ? pc_inc : r_pc;
            JC_IF_LINEAR: n_pc = i_status.shape_linear ? uw.target : pc_inc;
            JC_IF_SQRT:   n_pc = i_status.shape_sqrt ? uw.target : pc_inc;
            JC_WAIT_SQRT: n_pc = i_status.sqrt_busy ? r_pc : pc_inc;
            JC_WAIT_OUT:  n_pc = i_status.out_full ? r_pc : uw.target;
            default:      n_pc = PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.in_accept |=> (r_pc == PC_S1))
        else $error("accepted request did not start the program");

    a_sqrt_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.sqrt_busy |-> (r_pc == PC_SQRT_WAIT))
        else $error("square root running outside its wait step");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_OUT)
        else $error("step counter left the program");

endmodule

`default_nettype wire

// ----- src/gated_envelope_follower_unit.sv -----
// Top level of the gated envelope follower: configuration registers and unit wiring.
//
// Usage: each request on i_in carries one gate sample, one audio sample and
// their connected flags; each request produces exactly one control voltage
// on o_out (0 to 20480, 1/2048 V per LSB). Both channels use valid/ready and
// move a request at a clock edge where both are high. Configuration is
// written through i_cfg_we / i_cfg_idx / i_cfg_wdata while the unit is idle;
// indexes beyond the register list are ignored.
// After acceptance the program runs the follower and smoother steps and the
// envelope step, then the contour shaping (none for linear, a squaring
// multiply for square, a wait on the bit-serial square root unit for square
// root) and the product with the amount. A request is accepted only in the
// idle step that follows the output step, so the unit never takes a new
// request while the previous one is still in flight.
// The result waits in an output register; while the receiver stalls, the
// unit finishes the current request up to the output step and holds there.
// Synchronous reset restores the default coefficients, sets both followers
// to zero, the amount to one and the gate to low.
`default_nettype none

module gated_envelope_follower_unit
    import gef_pkg::*;
#(
    parameter int FRAC_BITS   = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    gef_in_if.sink                       i_in,
    gef_out_if.source                    o_out,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [FRAC_BITS:0]      i_cfg_wdata
);
    localparam int F = FRAC_BITS;

    // Defaults given at Q0.24, rescaled to the configured fraction width.
    localparam logic [63:0] ATTACK_RST  = (64'd34916 << FRAC_BITS) >> 24;
    localparam logic [63:0] RELEASE_RST = (64'd3495 << FRAC_BITS) >> 24;
    localparam logic [F:0]  ONE         = {1'b1, {F{1'b0}}};

    logic [F:0] r_attack_coeff;
    logic [F:0] r_release_coeff;
    logic [F:0] r_amount_slew_coeff;
    logic [F:0] r_amount_target;
    logic [1:0] r_contour_mode;
    logic       r_legacy_contour_map;

    t_uword     uword;
    t_dp_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coeff       <= ATTACK_RST[F:0];
            r_release_coeff      <= RELEASE_RST[F:0];
            r_amount_slew_coeff  <= ATTACK_RST[F:0];
            r_amount_target      <= ONE;
            r_contour_mode       <= 2'd0;
            r_legacy_contour_map <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:  r_attack_coeff       <= i_cfg_wdata;
                CFG_RELEASE: r_release_coeff      <= i_cfg_wdata;
                CFG_SLEW:    r_amount_slew_coeff  <= i_cfg_wdata;
                CFG_AMOUNT:  r_amount_target      <= i_cfg_wdata;
                CFG_CONTOUR: r_contour_mode       <= i_cfg_wdata[1:0];
                CFG_LEGACY:  r_legacy_contour_map <= i_cfg_wdata[0];
                default:     r_contour_mode       <= r_contour_mode;
            endcase
        end
    end

    gef_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    gef_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_uword              (uword),
        .o_status             (status),
        .i_in_valid           (i_in.valid),
        .o_in_ready           (i_in.ready),
        .i_gate_voltage       (i_in.gate_voltage),
        .i_audio_voltage      (i_in.audio_voltage),
        .i_gate_present       (i_in.gate_present),
        .i_audio_present      (i_in.audio_present),
        .i_attack_coeff       (r_attack_coeff),
        .i_release_coeff      (r_release_coeff),
        .i_amount_slew_coeff  (r_amount_slew_coeff),
        .i_amount_target      (r_amount_target),
        .i_contour_mode       (r_contour_mode),
        .i_legacy_contour_map (r_legacy_contour_map),
        .o_out_valid          (o_out.valid),
        .i_out_ready          (o_out.ready),
        .o_out_voltage        (o_out.out_voltage)
    );

endmodule

`default_nettype wire

// ----- tb/tb_gated_envelope_follower_unit.sv -----
// Self-checking testbench for the gated envelope follower unit.
module tb_gated_envelope_follower_unit
    import gef_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int REG_BITS    = FRAC_BITS + 1;

    localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
    localparam logic [REG_BITS-1:0] REG_ALL_ONES = '1;
    localparam logic [REG_BITS-1:0] REG_ONE = REG_BITS'(ONE_Q);

    localparam int GATE_ON_LSB    = 2048;
    localparam int GATE_OFF_LSB   = 205;
    localparam int FULL_SCALE_LSB = 10240;
    localparam int CV_SPAN_LSB    = 20480;

    localparam longint unsigned ATTACK_RST  = 34916;
    localparam longint unsigned RELEASE_RST = 3495;
    localparam longint unsigned SLEW_RST    = 34916;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    // Contour codes under the normal mapping. The legacy mapping swaps
    // linear and square root; code 3 is linear under both.
    localparam logic [1:0] CONTOUR_LINEAR = 2'd0;
    localparam logic [1:0] CONTOUR_SQUARE = 2'd1;
    localparam logic [1:0] CONTOUR_SQRT   = 2'd2;
    localparam logic [1:0] CONTOUR_SPARE  = 2'd3;

    localparam int SETTLE_CYCLES = FRAC_BITS + 24;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [FRAC_BITS:0]      i_cfg_wdata;

    gef_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    gef_out_if out_ch ();

    gated_envelope_follower_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted register copy and follower state.
    longint unsigned attack_k, release_k, depth_slew_k, depth_goal;
    logic [1:0]      contour_sel;
    logic            legacy_sel;
    longint unsigned gate_env, audio_env, depth_env;
    logic            gate_latched;

    logic [OUT_BITS-1:0] pending_cv[$];
    int                  error_count = 0;
    logic                no_gaps = 1'b0;

    function automatic longint unsigned sat_q(input longint unsigned v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    // One-pole step: move by ceil(k * distance), never past the goal.
    function automatic longint unsigned glide(input longint unsigned level,
                                              input longint unsigned goal,
                                              input longint unsigned k);
        longint unsigned span, stride;
        span   = (goal > level) ? goal - level : level - goal;
        stride = (k * span + ONE_Q - 1) >> FRAC_BITS;
        return (goal > level) ? level + stride : level - stride;
    endfunction

    function automatic longint unsigned root_q(input longint unsigned x);
        longint unsigned n, r, t;
        n = sat_q(x) << FRAC_BITS;
        r = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned contour(input longint unsigned x);
        if (contour_sel == CONTOUR_SQUARE)
            return (x * x) >> FRAC_BITS;
        if (legacy_sel)
            return (contour_sel == CONTOUR_LINEAR) ? root_q(x) : x;
        return (contour_sel == CONTOUR_SQRT) ? root_q(x) : x;
    endfunction

    function automatic logic [OUT_BITS-1:0] predict_cv(input logic signed [15:0] g,
                                                       input logic signed [15:0] a,
                                                       input logic g_on,
                                                       input logic a_on);
        longint unsigned gate_goal, audio_goal, env, prod;
        int mag;
        gate_goal  = 0;
        audio_goal = 0;
        depth_env  = glide(depth_env, sat_q(depth_goal), sat_q(depth_slew_k));
        if (g_on) begin
            if (gate_latched && g < GATE_OFF_LSB)
                gate_latched = 1'b0;
            else if (!gate_latched && g > GATE_ON_LSB)
                gate_latched = 1'b1;
            gate_goal = gate_latched ? ONE_Q : 0;
        end else begin
            gate_latched = 1'b0;
        end
        if (a_on) begin
            mag = (a < 0) ? -int'(a) : int'(a);
            if (mag >= FULL_SCALE_LSB)
                audio_goal = ONE_Q;
            else
                audio_goal = (longint'(mag) << FRAC_BITS) / FULL_SCALE_LSB;
        end
        gate_env  = glide(gate_env, gate_goal,
                          (gate_goal > gate_env) ? sat_q(attack_k) : sat_q(release_k));
        audio_env = glide(audio_env, audio_goal,
                          (audio_goal > audio_env) ? sat_q(attack_k) : sat_q(release_k));
        env  = (gate_env > audio_env) ? gate_env : audio_env;
        prod = (contour(env) * depth_env) >> FRAC_BITS;
        return OUT_BITS'((prod * CV_SPAN_LSB + (ONE_Q >> 1)) >> FRAC_BITS);
    endfunction

    function automatic logic [REG_BITS-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return REG_ONE;
            2:       return REG_ALL_ONES;
            3:       return REG_BITS'($urandom);
            default: return REG_BITS'($urandom_range(1 << 21, 1000));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ATTACK:  attack_k     = val;
            CFG_RELEASE: release_k    = val;
            CFG_SLEW:    depth_slew_k = val;
            CFG_AMOUNT:  depth_goal   = val;
            CFG_CONTOUR: contour_sel  = val[1:0];
            CFG_LEGACY:  legacy_sel   = val[0];
            default: ;
        endcase
    endtask

    // Drives one request and records its expected voltage on acceptance.
    // Returns at the accepting edge with valid still high, so a back-to-back
    // request never drops valid.
    task automatic send_sample(input logic signed [15:0] g, input logic signed [15:0] a,
                               input logic g_on, input logic a_on);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.gate_voltage  <= g;
        in_ch.audio_voltage <= a;
        in_ch.gate_present  <= g_on;
        in_ch.audio_present <= a_on;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_cv.push_back(predict_cv(g, a, g_on, a_on));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_cv.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_gate_hysteresis();
        send_sample(16'sd2048, 16'sd0, 1'b1, 1'b1);
        send_sample(16'sd2049, 16'sd0, 1'b1, 1'b1);
        send_sample(16'sd205, 16'sd0, 1'b1, 1'b1);
        send_sample(16'sd1000, 16'sd0, 1'b1, 1'b1);
        send_sample(16'sd204, 16'sd0, 1'b1, 1'b1);
        send_sample(16'sd2048, 16'sd0, 1'b1, 1'b1);
        send_sample(16'sd32767, 16'sd0, 1'b1, 1'b1);
        // A disconnected gate drops the latch even with a high sample.
        send_sample(16'sd32767, 16'sd0, 1'b0, 1'b1);
        send_sample(-16'sd32768, 16'sd0, 1'b1, 1'b1);
    endtask

    task automatic test_audio_levels();
        send_sample(16'sd0, 16'sd10239, 1'b1, 1'b1);
        send_sample(16'sd0, 16'sd10240, 1'b1, 1'b1);
        send_sample(16'sd0, -16'sd10240, 1'b1, 1'b1);
        send_sample(16'sd0, -16'sd32768, 1'b1, 1'b1);
        send_sample(16'sd0, 16'sd32767, 1'b1, 1'b1);
        send_sample(16'sd0, -16'sd1, 1'b1, 1'b1);
        send_sample(16'sd0, 16'sd32767, 1'b1, 1'b0);
    endtask

    task automatic test_spare_indexes();
        wait_idle();
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, REG_ALL_ONES);
        send_sample(16'sd4000, 16'sd5000, 1'b1, 1'b1);
    endtask

    task automatic test_contours();
        wait_idle();
        write_reg(CFG_ATTACK, REG_BITS'(ONE_Q >> 2));
        for (int lg = 0; lg < 2; lg++) begin
            for (int m = 0; m <= int'(CONTOUR_SPARE); m++) begin
                wait_idle();
                write_reg(CFG_CONTOUR, REG_BITS'(m));
                write_reg(CFG_LEGACY, REG_BITS'(lg));
                send_sample(16'sd3000, 16'($urandom), 1'b1, 1'b1);
            end
        end
    endtask

    // Gate pulses of random length with random content, plus noise, samples
    // inside the hysteresis band and disconnected inputs.
    task automatic test_random_mix();
        logic signed [15:0] g, a;
        logic               g_on, a_on, pulse_high;
        logic [REG_BITS-1:0] filler;
        int                 run_left, mag, pick;
        pulse_high = 1'b0;
        run_left   = 5;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            filler = REG_BITS'($urandom);
            if (ph == 0) begin
                write_reg(CFG_ATTACK, REG_ALL_ONES);
                write_reg(CFG_RELEASE, REG_ONE);
                write_reg(CFG_SLEW, REG_ALL_ONES);
                write_reg(CFG_AMOUNT, REG_ALL_ONES);
                write_reg(CFG_CONTOUR, {filler[REG_BITS-1:2], CONTOUR_SQRT});
                write_reg(CFG_LEGACY, {filler[REG_BITS-1:1], 1'b0});
            end else if (ph == 1) begin
                write_reg(CFG_ATTACK, '0);
                write_reg(CFG_RELEASE, '0);
                write_reg(CFG_SLEW, '0);
                write_reg(CFG_AMOUNT, '0);
                write_reg(CFG_CONTOUR, {filler[REG_BITS-1:2], CONTOUR_SQUARE});
                write_reg(CFG_LEGACY, {filler[REG_BITS-1:1], 1'b1});
            end else begin
                write_reg(CFG_ATTACK, pick_coeff());
                write_reg(CFG_RELEASE, pick_coeff());
                write_reg(CFG_SLEW, pick_coeff());
                write_reg(CFG_AMOUNT, pick_coeff());
                write_reg(CFG_CONTOUR, filler);
                write_reg(CFG_LEGACY, REG_BITS'($urandom));
            end
            no_gaps = (ph % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    g = 16'($urandom);
                else if (pick < 4)
                    g = 16'($urandom_range(GATE_ON_LSB, GATE_OFF_LSB));
                else if (pulse_high)
                    g = 16'($urandom_range(32767, GATE_ON_LSB + 1));
                else
                    g = 16'(int'($urandom_range(32767 + GATE_OFF_LSB, 0)) - 32768);
                run_left--;
                if (run_left <= 0) begin
                    pulse_high = !pulse_high;
                    run_left   = $urandom_range(1, 24);
                end
                if ($urandom_range(0, 2) == 0) begin
                    a = 16'($urandom);
                end else begin
                    mag = $urandom_range(0, 12000);
                    a   = 16'($urandom_range(0, 1) ? -mag : mag);
                end
                g_on = ($urandom_range(0, 15) != 0);
                a_on = ($urandom_range(0, 15) != 0);
                send_sample(g, a, g_on, a_on);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_wdata         = '0;
        in_ch.valid         = 1'b0;
        in_ch.gate_voltage  = '0;
        in_ch.audio_voltage = '0;
        in_ch.gate_present  = 1'b0;
        in_ch.audio_present = 1'b0;
        out_ch.ready        = 1'b0;
        attack_k     = ATTACK_RST;
        release_k    = RELEASE_RST;
        depth_slew_k = SLEW_RST;
        depth_goal   = ONE_Q;
        contour_sel  = CONTOUR_LINEAR;
        legacy_sel   = 1'b0;
        gate_env     = 0;
        audio_env    = 0;
        depth_env    = ONE_Q;
        gate_latched = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_gate_hysteresis();
        test_audio_levels();
        test_spare_indexes();
        test_contours();
        test_random_mix();
        wait_idle();

        if (error_count == 0)
            $display("tb_gated_envelope_follower_unit: clean");
        else
            $display("tb_gated_envelope_follower_unit: errors");
        $finish;
    end

    // Receiver: a random stall before each result, none in gap-free phases.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_cv.size() == 0) begin
                $display("%t: unexpected out_voltage %0d", $time, out_ch.out_voltage);
                error_count++;
            end else begin
                if (out_ch.out_voltage !== pending_cv[0]) begin
                    $display("%t: out_voltage expected %0d, got %0d",
                             $time, pending_cv[0], out_ch.out_voltage);
                    error_count++;
                end
                void'(pending_cv.pop_front());
            end
        end
    end

    initial begin
        #3_000_000;
        $display("tb_gated_envelope_follower_unit: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/gef_pkg.sv
src/gef_in_if.sv
src/gef_out_if.sv
src/gef_sqrt.sv
src/gef_datapath.sv
src/gef_sequencer.sv
src/gated_envelope_follower_unit.sv
tb/tb_gated_envelope_follower_unit.sv
